// ===== sv/hdlf_pkg.sv =====
package hdlf_pkg;

	localparam int BYTES_PER_LINE = 16;
	localparam int OFFSET_BITS    = 32;
	localparam int OFS_DIGITS     = ((OFFSET_BITS + 3) / 4 > 8) ? (OFFSET_BITS + 3) / 4 : 8;
	localparam int DIG_BITS       = 4 * OFS_DIGITS;
	localparam int FILL_W         = $clog2(BYTES_PER_LINE + 1);
	localparam int IDX_W          = $clog2(BYTES_PER_LINE);
	localparam int CNT_MAX        = (OFS_DIGITS > BYTES_PER_LINE) ? OFS_DIGITS : BYTES_PER_LINE;
	localparam int CNT_W          = $clog2(CNT_MAX);

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] PRINT_LO = 8'd32;
	localparam logic [7:0] PRINT_HI = 8'd126;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_OFS,
		ST_COLON,
		ST_SPACE,
		ST_HEXHI,
		ST_HEXLO,
		ST_BSPC,
		ST_PAD,
		ST_ASCII,
		ST_NL
	} state_t;

	typedef enum logic [2:0] {
		SEL_OFS,
		SEL_COLON,
		SEL_SPACE,
		SEL_HEXHI,
		SEL_HEXLO,
		SEL_TEXT,
		SEL_NL
	} csel_t;

	typedef struct packed {
		logic  load;
		logic  emit;
		logic  last;
		csel_t sel;
		logic  commit;
		logic  fill_clr;
		logic  cnt_clr;
		logic  cnt_inc;
		logic  cnt_fill;
		logic  sub_clr;
		logic  sub_inc;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
		logic fill_zero;
		logic fill_odd;
		logic fill_last;
		logic fill_full;
		logic ofs_done;
		logic pad_done;
		logic grp_done;
		logic text_done;
	} dp_stat_t;

	function automatic logic [7:0] hex_glyph(input logic [3:0] nib);
		logic [7:0] wide;
		wide = {4'b0000, nib};
		return (nib < 4'd10) ? (8'h30 + wide) : (8'h37 + wide);
	endfunction

endpackage

// ===== sv/hdlf_byte_if.sv =====
interface hdlf_byte_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [7:0] data_byte;

	modport source (output valid, output mode, output data_byte, input ready);
	modport sink (input valid, input mode, input data_byte, output ready);
endinterface

// ===== sv/hdlf_char_if.sv =====
interface hdlf_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       run_last;

	modport source (output valid, output out_char, output run_last, input ready);
	modport sink (input valid, input out_char, input run_last, output ready);
endinterface

// ===== sv/hdlf_ctrl.sv =====
module hdlf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_mode,
	output logic              in_ready,
	input  hdlf_pkg::dp_stat_t stat,
	output hdlf_pkg::dp_cmd_t  cmd
);

	hdlf_pkg::state_t state_q;
	hdlf_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hdlf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == hdlf_pkg::ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.sel = hdlf_pkg::SEL_SPACE;
		unique case (state_q)
			hdlf_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (!in_mode) begin
						cmd.load = 1'b1;
						if (stat.fill_zero) begin
							cmd.cnt_clr = 1'b1;
							state_d     = hdlf_pkg::ST_OFS;
						end else begin
							state_d = hdlf_pkg::ST_HEXHI;
						end
					end else if (!stat.fill_zero) begin
						cmd.cnt_fill = 1'b1;
						cmd.sub_clr  = 1'b1;
						state_d      = hdlf_pkg::ST_PAD;
					end
				end
			end
			hdlf_pkg::ST_OFS: begin
				cmd.sel = hdlf_pkg::SEL_OFS;
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					if (stat.ofs_done) begin
						state_d = hdlf_pkg::ST_COLON;
					end else begin
						cmd.cnt_inc = 1'b1;
					end
				end
			end
			hdlf_pkg::ST_COLON: begin
				cmd.sel = hdlf_pkg::SEL_COLON;
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = hdlf_pkg::ST_SPACE;
				end
			end
			hdlf_pkg::ST_SPACE: begin
				cmd.sel = hdlf_pkg::SEL_SPACE;
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = hdlf_pkg::ST_HEXHI;
				end
			end
			hdlf_pkg::ST_HEXHI: begin
				cmd.sel = hdlf_pkg::SEL_HEXHI;
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = hdlf_pkg::ST_HEXLO;
				end
			end
			hdlf_pkg::ST_HEXLO: begin
				cmd.sel = hdlf_pkg::SEL_HEXLO;
				if (stat.out_free) begin
					cmd.emit   = 1'b1;
					cmd.commit = 1'b1;
					if (stat.fill_odd) begin
						state_d = hdlf_pkg::ST_BSPC;
					end else if (stat.fill_last) begin
						cmd.cnt_clr = 1'b1;
						state_d     = hdlf_pkg::ST_ASCII;
					end else begin
						cmd.last = 1'b1;
						state_d  = hdlf_pkg::ST_IDLE;
					end
				end
			end
			hdlf_pkg::ST_BSPC: begin
				cmd.sel = hdlf_pkg::SEL_SPACE;
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					if (stat.fill_full) begin
						cmd.cnt_clr = 1'b1;
						state_d     = hdlf_pkg::ST_ASCII;
					end else begin
						cmd.last = 1'b1;
						state_d  = hdlf_pkg::ST_IDLE;
					end
				end
			end
			hdlf_pkg::ST_PAD: begin
				cmd.sel = hdlf_pkg::SEL_SPACE;
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					if (stat.grp_done) begin
						cmd.sub_clr = 1'b1;
						if (stat.pad_done) begin
							cmd.cnt_clr = 1'b1;
							state_d     = hdlf_pkg::ST_ASCII;
						end else begin
							cmd.cnt_inc = 1'b1;
						end
					end else begin
						cmd.sub_inc = 1'b1;
					end
				end
			end
			hdlf_pkg::ST_ASCII: begin
				cmd.sel = hdlf_pkg::SEL_TEXT;
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					if (stat.text_done) begin
						state_d = hdlf_pkg::ST_NL;
					end else begin
						cmd.cnt_inc = 1'b1;
					end
				end
			end
			hdlf_pkg::ST_NL: begin
				cmd.sel = hdlf_pkg::SEL_NL;
				if (stat.out_free) begin
					cmd.emit     = 1'b1;
					cmd.last     = 1'b1;
					cmd.fill_clr = 1'b1;
					state_d      = hdlf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = hdlf_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== sv/hdlf_dpath.sv =====
module hdlf_dpath (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         data_byte,
	input  hdlf_pkg::dp_cmd_t  cmd,
	output hdlf_pkg::dp_stat_t stat,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         out_char,
	output logic               run_last
);

	logic [7:0]                       byte_q;
	logic [hdlf_pkg::OFFSET_BITS-1:0] ofs_q;
	logic [hdlf_pkg::FILL_W-1:0]      fill_q;
	logic [hdlf_pkg::CNT_W-1:0]       cnt_q;
	logic [1:0]                       sub_q;
	logic [7:0]                       text_q [hdlf_pkg::BYTES_PER_LINE];
	logic                             out_valid_q;
	logic [7:0]                       out_char_q;
	logic                             out_last_q;

	logic [hdlf_pkg::DIG_BITS-1:0] ofs_ext;
	logic [hdlf_pkg::CNT_W-1:0]    dig_idx;
	logic [3:0]                    ofs_nib;
	logic [7:0]                    shown;
	logic [7:0]                    char_d;
	logic [hdlf_pkg::CNT_W:0]      cnt_next;

	assign ofs_ext  = hdlf_pkg::DIG_BITS'(ofs_q);
	assign dig_idx  = hdlf_pkg::CNT_W'(hdlf_pkg::OFS_DIGITS - 1) - cnt_q;
	assign ofs_nib  = ofs_ext[dig_idx*4 +: 4];
	assign shown    = (byte_q >= hdlf_pkg::PRINT_LO && byte_q <= hdlf_pkg::PRINT_HI)
	                  ? byte_q : hdlf_pkg::CH_DOT;
	assign cnt_next = {1'b0, cnt_q} + 1'b1;

	always_comb begin
		unique case (cmd.sel)
			hdlf_pkg::SEL_OFS:   char_d = hdlf_pkg::hex_glyph(ofs_nib);
			hdlf_pkg::SEL_COLON: char_d = hdlf_pkg::CH_COLON;
			hdlf_pkg::SEL_SPACE: char_d = hdlf_pkg::CH_SPACE;
			hdlf_pkg::SEL_HEXHI: char_d = hdlf_pkg::hex_glyph(byte_q[7:4]);
			hdlf_pkg::SEL_HEXLO: char_d = hdlf_pkg::hex_glyph(byte_q[3:0]);
			hdlf_pkg::SEL_TEXT:  char_d = text_q[cnt_q[hdlf_pkg::IDX_W-1:0]];
			hdlf_pkg::SEL_NL:    char_d = hdlf_pkg::CH_NL;
			default:             char_d = hdlf_pkg::CH_SPACE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ofs_q       <= '0;
			fill_q      <= '0;
			cnt_q       <= '0;
			sub_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				ofs_q  <= ofs_q + 1'b1;
				fill_q <= fill_q + 1'b1;
			end else if (cmd.fill_clr) begin
				fill_q <= '0;
			end
			if (cmd.cnt_clr) begin
				cnt_q <= '0;
			end else if (cmd.cnt_fill) begin
				cnt_q <= hdlf_pkg::CNT_W'(fill_q);
			end else if (cmd.cnt_inc) begin
				cnt_q <= cnt_next[hdlf_pkg::CNT_W-1:0];
			end
			if (cmd.sub_clr) begin
				sub_q <= '0;
			end else if (cmd.sub_inc) begin
				sub_q <= sub_q + 2'd1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			byte_q <= data_byte;
		end
		if (cmd.commit) begin
			text_q[fill_q[hdlf_pkg::IDX_W-1:0]] <= shown;
		end
		if (cmd.emit) begin
			out_char_q <= char_d;
			out_last_q <= cmd.last;
		end
	end

	assign stat.out_free  = !out_valid_q || out_ready;
	assign stat.fill_zero = (fill_q == '0);
	assign stat.fill_odd  = fill_q[0];
	assign stat.fill_last = (fill_q == hdlf_pkg::FILL_W'(hdlf_pkg::BYTES_PER_LINE - 1));
	assign stat.fill_full = (fill_q == hdlf_pkg::FILL_W'(hdlf_pkg::BYTES_PER_LINE));
	assign stat.ofs_done  = (cnt_q == hdlf_pkg::CNT_W'(hdlf_pkg::OFS_DIGITS - 1));
	assign stat.pad_done  = (cnt_q == hdlf_pkg::CNT_W'(hdlf_pkg::BYTES_PER_LINE - 1));
	assign stat.grp_done  = (sub_q == (cnt_q[0] ? 2'd2 : 2'd1));
	assign stat.text_done = (cnt_next == (hdlf_pkg::CNT_W + 1)'(fill_q));

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign run_last  = out_last_q;

endmodule

// ===== sv/hex_dump_line_formatter_core.sv =====
// Hex dump formatter: each request on byte_stream is a data byte or an end-of-stream
// flush; the text comes out on char_stream one character per cycle unless char_stream
// stalls, run_last on the final character of each request. Every request is first taken
// in, then its characters are written out. A data byte gives two hex digits and
// a space after odd positions, 10 more characters when it opens a line (8 offset digits,
// ':' and ' '), and 17 more when it closes a 16-byte line (ASCII column and newline), so
// a full line of 16 bytes costs 67 characters. A flush of a line holding n bytes gives
// the padding (2 or 3 spaces per missing position) plus n + 1 characters; a flush of an
// empty line gives nothing. The single output register paces the text: the sequencer
// writes one character into it per cycle and stalls while char_stream holds it. A new
// request is taken as soon as the last character of the previous one is in that
// register.
module hex_dump_line_formatter_core (
	input  logic        clk,
	input  logic        arst_n,
	hdlf_byte_if.sink   byte_stream,
	hdlf_char_if.source char_stream
);

	hdlf_pkg::dp_cmd_t  cmd;
	hdlf_pkg::dp_stat_t stat;

	hdlf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (byte_stream.valid),
		.in_mode  (byte_stream.mode),
		.in_ready (byte_stream.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	hdlf_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_byte (byte_stream.data_byte),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (char_stream.valid),
		.out_ready (char_stream.ready),
		.out_char  (char_stream.out_char),
		.run_last  (char_stream.run_last)
	);

endmodule

// ===== sv/hdlf_checker.sv =====
module hdlf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       in_mode,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_char,
	input logic       run_last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(run_last))
		else $error("stalled character changed");

	a_text_char: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_char == 8'h0A) || (out_char >= 8'd32 && out_char <= 8'd126))
		else $error("character outside dump alphabet");

	a_busy_after_byte: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !in_mode |=> !in_ready)
		else $error("data byte request produced no text");

	a_last_char: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && run_last |-> (out_char == 8'h0A) || (out_char == 8'h20)
			|| (out_char >= 8'h30 && out_char <= 8'h39)
			|| (out_char >= 8'h41 && out_char <= 8'h46))
		else $error("request ended on unexpected character");

endmodule

bind hex_dump_line_formatter_core hdlf_checker u_hdlf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (byte_stream.valid),
	.in_ready  (byte_stream.ready),
	.in_mode   (byte_stream.mode),
	.out_valid (char_stream.valid),
	.out_ready (char_stream.ready),
	.out_char  (char_stream.out_char),
	.run_last  (char_stream.run_last)
);
